>>> rtl/core/grdt_pkg.sv
package grdt_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_TARGET_X      = 2'd0;
    localparam logic [1:0] REG_TARGET_Y      = 2'd1;
    localparam logic [1:0] REG_REGION_RADIUS = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // field widths
    localparam int TIME_W   = 32;
    localparam int COORD_W  = 16;
    localparam int TARGET_W = 12;
    localparam int RADIUS_W = 11;
    localparam int COUNT_W  = 16;

    // stream payload widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 88;

    // classified sample handed from front to back
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic              hit;
    } t_cls;

endpackage

>>> rtl/core/grdt_front.sv
module grdt_front #(
    parameter int QUEUE_DEPTH = 8,
    parameter int CNT_W       = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [grdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [grdt_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // incoming samples
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [grdt_pkg::TIME_W-1:0]    i_stamp,
    input  logic [grdt_pkg::COORD_W-1:0]   i_gaze_x,
    input  logic [grdt_pkg::COORD_W-1:0]   i_gaze_y,
    input  logic                           i_fix_flag,
    // queue occupancy, used as credit
    input  logic [CNT_W-1:0]               i_q_count,
    // classified samples toward the queue
    output logic                           o_push,
    output grdt_pkg::t_cls                 o_cls
);
    import grdt_pkg::*;

    localparam int DX_W  = COORD_W + 1;
    localparam int SQ_W  = 2 * COORD_W;
    localparam int R2_W  = 2 * RADIUS_W;
    localparam int USE_W = CNT_W + 1;

    // configuration registers
    logic signed [TARGET_W-1:0] r_tx;
    logic signed [TARGET_W-1:0] r_ty;
    logic        [RADIUS_W-1:0] r_radius;

    // stage 1: differences
    logic                     r_s1_vld;
    logic [TIME_W-1:0]        r_s1_stamp;
    logic                     r_s1_flag;
    logic signed [DX_W-1:0]   r_s1_dx;
    logic signed [DX_W-1:0]   r_s1_dy;

    // stage 2: squares
    logic                     r_s2_vld;
    logic [TIME_W-1:0]        r_s2_stamp;
    logic                     r_s2_flag;
    logic [SQ_W-1:0]          r_s2_sqx;
    logic [SQ_W-1:0]          r_s2_sqy;
    logic [R2_W-1:0]          r_s2_r2;

    logic                     w_accept;
    logic [USE_W-1:0]         w_used;
    logic signed [DX_W-1:0]   w_dx;
    logic signed [DX_W-1:0]   w_dy;
    logic signed [2*DX_W-1:0] w_px;
    logic signed [2*DX_W-1:0] w_py;
    logic [SQ_W:0]            w_d2;
    logic [SQ_W:0]            w_lim;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx     <= '0;
            r_ty     <= '0;
            r_radius <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_TARGET_X)
                r_tx <= i_cfg_wdata[TARGET_W-1:0];
            if (i_cfg_idx == REG_TARGET_Y)
                r_ty <= i_cfg_wdata[TARGET_W-1:0];
            if (i_cfg_idx == REG_REGION_RADIUS)
                r_radius <= i_cfg_wdata[RADIUS_W-1:0];
        end
    end

    // credit: queue entries plus samples still in the pipe must leave room
    assign w_used   = USE_W'(i_q_count) + USE_W'(r_s1_vld) + USE_W'(r_s2_vld);
    assign o_ready  = (w_used < USE_W'(QUEUE_DEPTH));
    assign w_accept = i_valid && o_ready;

    // target scaled to q12.4, differences in 17 bits
    assign w_dx = DX_W'($signed(i_gaze_x)) - DX_W'($signed({r_tx, 4'b0000}));
    assign w_dy = DX_W'($signed(i_gaze_y)) - DX_W'($signed({r_ty, 4'b0000}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_stamp <= i_stamp;
        r_s1_flag  <= i_fix_flag;
        r_s1_dx    <= w_dx;
        r_s1_dy    <= w_dy;
    end

    // squares; a square of a 17-bit value here stays below 2^32
    assign w_px = r_s1_dx * r_s1_dx;
    assign w_py = r_s1_dy * r_s1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_stamp <= r_s1_stamp;
        r_s2_flag  <= r_s1_flag;
        r_s2_sqx   <= w_px[SQ_W-1:0];
        r_s2_sqy   <= w_py[SQ_W-1:0];
        r_s2_r2    <= R2_W'(r_radius) * R2_W'(r_radius);
    end

    // distance compare against radius squared, both in q.8
    assign w_d2  = (SQ_W+1)'(r_s2_sqx) + (SQ_W+1)'(r_s2_sqy);
    assign w_lim = (SQ_W+1)'({r_s2_r2, 8'h00});

    assign o_push      = r_s2_vld;
    assign o_cls.stamp = r_s2_stamp;
    assign o_cls.hit   = r_s2_flag && (w_d2 < w_lim);

endmodule

>>> rtl/core/grdt_queue.sv
module grdt_queue #(
    parameter int DEPTH = 8,
    parameter int CNT_W = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  grdt_pkg::t_cls i_data,
    input  logic           i_pop,
    output grdt_pkg::t_cls o_data,
    output logic           o_empty,
    output logic [CNT_W-1:0] o_count
);
    import grdt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    // pointers and occupancy
    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            r_count <= n_count;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    // credit scheme must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(DEPTH)) |-> !i_push || i_pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/core/grdt_back.sv
module grdt_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // classified samples from the queue
    input  logic                              i_empty,
    input  grdt_pkg::t_cls                    i_cls,
    output logic                              o_pop,
    // result stream
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [grdt_pkg::M_TDATA_W-1:0]    o_data
);
    import grdt_pkg::*;

    localparam int PAY_W = 1 + COUNT_W + 2 * TIME_W;

    logic               r_fixated;
    logic [COUNT_W-1:0] r_entries;
    logic [TIME_W-1:0]  r_dwell;
    logic [TIME_W-1:0]  r_gap;
    logic [TIME_W-1:0]  r_last;

    logic               n_fixated;
    logic [COUNT_W-1:0] n_entries;
    logic [TIME_W-1:0]  n_dwell;
    logic [TIME_W-1:0]  n_gap;
    logic [TIME_W-1:0]  n_last;

    logic               r_out_vld;
    logic [PAY_W-1:0]   r_out_data;

    logic [TIME_W-1:0]  w_span;
    logic [TIME_W:0]    w_dsum;
    logic [TIME_W-1:0]  w_dsat;

    // take a sample when the output register is free or being drained
    assign o_pop = !i_empty && (!r_out_vld || i_ready);

    // elapsed time and saturating dwell add
    assign w_span = i_cls.stamp - r_last;
    assign w_dsum = (TIME_W+1)'(r_dwell) + (TIME_W+1)'(w_span);
    assign w_dsat = w_dsum[TIME_W] ? '1 : w_dsum[TIME_W-1:0];

    // fixation state update
    always_comb begin
        n_fixated = r_fixated;
        n_entries = r_entries;
        n_dwell   = r_dwell;
        n_gap     = r_gap;
        n_last    = r_last;
        priority if (i_cls.hit && !r_fixated) begin
            n_fixated = 1'b1;
            if (r_entries != '1)
                n_entries = r_entries + COUNT_W'(1);
            if (r_last != '0)
                n_gap = w_span;
            n_last = i_cls.stamp;
        end else if (r_fixated) begin
            n_fixated = i_cls.hit;
            n_dwell   = w_dsat;
            n_last    = i_cls.stamp;
        end else begin
            n_fixated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixated <= 1'b0;
            r_entries <= '0;
            r_dwell   <= '0;
            r_gap     <= '0;
            r_last    <= '0;
        end else if (o_pop) begin
            r_fixated <= n_fixated;
            r_entries <= n_entries;
            r_dwell   <= n_dwell;
            r_gap     <= n_gap;
            r_last    <= n_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_pop) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_out_data <= {n_gap, n_dwell, n_entries, n_fixated};
    end

    assign o_valid = r_out_vld;
    assign o_data  = {(M_TDATA_W - PAY_W)'(0), r_out_data};

    // entry count only moves up
    a_entries_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_entries >= $past(r_entries))
        else $error("entry count decreased");

    // an ongoing fixation has always been counted
    a_fix_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fixated |-> r_entries != '0)
        else $error("fixation without entry count");

endmodule

>>> rtl/core/gaze_region_dwell_tracker.sv
// Gaze region dwell tracker. Each accepted gaze sample produces exactly one result
// transaction carrying on_target, fix_count, dwell_total and gap_time after the update.
// One sample per clock is sustained while m_axis_tready is high: a two-stage classifier
// (difference, then squares and distance compare) feeds a small queue, and the back end
// updates the fixation state per sample and holds the result in an output register,
// reached through the stage-1 and stage-2 registers and a queue entry. s_axis_tready
// drops only when queue entries plus samples in the classifier reach QUEUE_DEPTH, i.e.
// when the result side has been stalled for a while. The user must write configuration
// via i_cfg_we / i_cfg_idx / i_cfg_wdata only while idle; the block does not enforce it.
module gaze_region_dwell_tracker #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [grdt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [grdt_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // sample stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_time[31:0], gaze_x[47:32], gaze_y[63:48]
    input  logic [grdt_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // fix_flag[0]
    input  logic                                 s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // on_target[0], fix_count[16:1], dwell_total[48:17], gap_time[80:49], zero[87:81]
    output logic [grdt_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
    import grdt_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             w_push;
    t_cls             w_push_cls;
    logic             w_pop;
    t_cls             w_pop_cls;
    logic             w_empty;
    logic [CNT_W-1:0] w_q_count;

    // front: accept and classify samples
    grdt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_stamp     (s_axis_tdata[31:0]),
        .i_gaze_x    (s_axis_tdata[47:32]),
        .i_gaze_y    (s_axis_tdata[63:48]),
        .i_fix_flag  (s_axis_tuser),
        .i_q_count   (w_q_count),
        .o_push      (w_push),
        .o_cls       (w_push_cls)
    );

    // queue between classifier and state update
    grdt_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cls),
        .i_pop   (w_pop),
        .o_data  (w_pop_cls),
        .o_empty (w_empty),
        .o_count (w_q_count)
    );

    // back: fixation state and result register
    grdt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cls   (w_pop_cls),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule
